@@ sv/plen_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plen_pkg: shared types and constants of the positional list engine
// Holds the list sizes, the operation codes, the word structs of both
// channels and the control struct that drives the row of list cells.
// ----------------------------------------------------------------------------
`default_nettype none

package plen_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int OP_W       = 4;
    localparam int POS_W      = 7;
    localparam int VAL_W      = 32;
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int GRP_N      = 8;
    localparam int NGRP       = (CAPACITY + GRP_N - 1) / GRP_N;

    typedef logic [DATA_WIDTH-1:0] t_data;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 4'd0,
        OP_INS_BACK  = 4'd1,
        OP_INS_AT    = 4'd2,
        OP_REM_FRONT = 4'd3,
        OP_REM_BACK  = 4'd4,
        OP_REM_AT    = 4'd5,
        OP_RD_FRONT  = 4'd6,
        OP_RD_BACK   = 4'd7,
        OP_RD_AT     = 4'd8,
        OP_CLEAR     = 4'd9
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic             status;
        logic [VAL_W-1:0] read_data;
        logic [POS_W-1:0] entry_count;
        logic             nonempty;
    } t_out_word;

    typedef struct packed {
        logic             exec;
        logic             ins;
        logic             rem;
        logic             pick;
        logic [CMP_W-1:0] pos;
        t_data            data;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/plen_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plen_cell: one entry of the list
// Holds one data word; takes its left neighbor on an insert below it, the
// new word at the insert position and its right neighbor on a remove.
// ----------------------------------------------------------------------------
`default_nettype none

module plen_cell import plen_pkg::*; (
    input  wire logic             i_clk,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CMP_W-1:0] i_idx,
    input  wire t_data            i_prev,
    input  wire t_data            i_next,
    output t_data                 o_word,
    output t_data                 o_pick
);

    t_data r_word;
    t_data n_word;
    logic  hit;

    assign hit = (i_idx == i_ctl.pos);

    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (hit) begin
                n_word = i_ctl.data;
            end else if (i_idx > i_ctl.pos) begin
                n_word = i_prev;
            end
        end else if (i_ctl.rem && (i_idx >= i_ctl.pos)) begin
            n_word = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_pick = (i_ctl.pick && hit) ? r_word : '0;

endmodule

`default_nettype wire

@@ sv/plen_row.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plen_row: the chain of list cells and the read-out tree
// Links every cell to its neighbors and collects the picked word through
// a registered group stage followed by a final or over the groups.
// ----------------------------------------------------------------------------
`default_nettype none

module plen_row import plen_pkg::*; (
    input  wire logic      i_clk,
    input  wire t_cell_ctl i_ctl,
    output t_data          o_pick
);

    t_data word [CAPACITY];
    t_data pick [CAPACITY];
    t_data r_grp [NGRP];
    t_data n_grp [NGRP];

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        t_data prev_w;
        t_data next_w;
        if (gi == 0) begin : g_first
            assign prev_w = '0;
        end else begin : g_mid_p
            assign prev_w = word[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign next_w = '0;
        end else begin : g_mid_n
            assign next_w = word[gi+1];
        end
        plen_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (i_ctl),
            .i_idx  (CMP_W'(gi)),
            .i_prev (prev_w),
            .i_next (next_w),
            .o_word (word[gi]),
            .o_pick (pick[gi])
        );
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
            for (int m = 0; m < GRP_N; m++) begin
                if (g * GRP_N + m < CAPACITY) begin
                    n_grp[g] = n_grp[g] | pick[g * GRP_N + m];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_grp <= n_grp;
        end
    end

    always_comb begin
        o_pick = '0;
        for (int g = 0; g < NGRP; g++) begin
            o_pick = o_pick | r_grp[g];
        end
    end

endmodule

`default_nettype wire

@@ sv/positional_list_engine_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of up to CAPACITY data words
// Each input word is one operation: insert, remove or read at the front,
// the back or a position, or clear. Each yields exactly one output word
// with status, the word read or removed, the entry count and a nonempty
// flag.
// Channels: input word on i_in_valid / o_in_stall, output word on
// o_out_valid / i_out_stall; a word moves when valid is high and stall low.
// Steps: the input word is registered, the EXEC state shifts the cell row
// and registers the group read-out, and the DONE state merges the groups
// into the output. One operation is in flight at a time, so the block takes
// no new input word until the last one has reached the output register.
// The output register holds a finished word while the next one is taken.
// Reset: the entry count goes to zero and no output word is pending;
// cell contents are not cleared.
// A stalled output word holds; the next operation waits in its DONE state
// until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine_unit import plen_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    input  wire t_in_word i_in_word,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_out_word     o_out_word
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state;
    t_state           n_state;
    t_in_word         r_in;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_status;
    logic             r_out_vld;
    t_out_word        r_out;

    logic             k_ins;
    logic             k_rem;
    logic             k_rd;
    logic             k_clr;
    logic [CMP_W-1:0] eff;
    logic [CMP_W-1:0] cnt_c;
    logic             ok;
    logic             in_acc;
    logic             out_free;
    logic             done_go;
    t_cell_ctl        ctl;
    t_data            pick;

    assign cnt_c    = CMP_W'(r_count);
    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_vld || !i_out_stall;
    assign done_go  = (r_state == S_DONE) && out_free;

    always_comb begin
        k_ins = 1'b0;
        k_rem = 1'b0;
        k_rd  = 1'b0;
        k_clr = 1'b0;
        eff   = '0;
        unique case (r_in.op)
            OP_INS_FRONT: begin k_ins = 1'b1; eff = '0; end
            OP_INS_BACK:  begin k_ins = 1'b1; eff = cnt_c; end
            OP_INS_AT:    begin k_ins = 1'b1; eff = CMP_W'(r_in.position); end
            OP_REM_FRONT: begin k_rem = 1'b1; eff = '0; end
            OP_REM_BACK:  begin k_rem = 1'b1; eff = cnt_c - CMP_W'(1); end
            OP_REM_AT:    begin k_rem = 1'b1; eff = CMP_W'(r_in.position); end
            OP_RD_FRONT:  begin k_rd = 1'b1; eff = '0; end
            OP_RD_BACK:   begin k_rd = 1'b1; eff = cnt_c - CMP_W'(1); end
            OP_RD_AT:     begin k_rd = 1'b1; eff = CMP_W'(r_in.position); end
            OP_CLEAR:     begin k_clr = 1'b1; end
            default:      begin end
        endcase
    end

    always_comb begin
        if (k_ins) begin
            ok = (r_count < CNT_W'(CAPACITY)) && (eff <= cnt_c);
        end else if (k_rem || k_rd) begin
            ok = (r_count != '0) && (eff < cnt_c);
        end else begin
            ok = k_clr;
        end
    end

    always_comb begin
        ctl.exec = (r_state == S_EXEC);
        ctl.ins  = ctl.exec && k_ins && ok;
        ctl.rem  = ctl.exec && k_rem && ok;
        ctl.pick = (k_rem || k_rd) && ok;
        ctl.pos  = eff;
        ctl.data = t_data'(r_in.value);
    end

    plen_row u_row (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .o_pick (pick)
    );

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (ctl.rem) begin
            n_count = r_count - CNT_W'(1);
        end else if (ctl.exec && k_clr) begin
            n_count = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (in_acc) begin n_state = S_EXEC; end
            S_EXEC:  n_state = S_DONE;
            S_DONE:  if (out_free) begin n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (done_go) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_word;
        end
        if (ctl.exec) begin
            r_status <= !ok;
        end
        if (done_go) begin
            r_out.status      <= r_status;
            r_out.read_data   <= VAL_W'(pick);
            r_out.entry_count <= POS_W'(r_count);
            r_out.nonempty    <= (r_count != '0);
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

    // count stays within the list size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // an accepted word starts execution in the next cycle
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == S_EXEC))
        else $error("accepted word did not execute");

    // a new output word only comes from the final step
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid && i_out_stall)) |->
            $past(r_state == S_DONE))
        else $error("output word without a finished operation");

    // a failed operation returns no data
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.status) |-> (o_out_word.read_data == '0))
        else $error("failed operation carries data");

    // the nonempty flag tracks the count
    a_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.nonempty == (o_out_word.entry_count != '0)))
        else $error("nonempty flag disagrees with count");

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: positional list engine unit
// Drives list operations through the input channel and checks every output
// word against an in-bench model of the list kept as a queue of words.
// A short table of directed operations runs first, the empty case, bad
// positions, extreme values, unused codes and clear among them. Random
// phases follow that fill the list to full, drain it to empty, mix all
// operations and throw in raw noise, with bursts of idle on both channels.
// ----------------------------------------------------------------------------

module testbench;
    import plen_pkg::*;

    localparam int RAND_ITEMS     = 424;
    localparam int QUIET_TAIL     = 60;
    localparam int DRAIN_CYCLES   = 10;
    localparam int WATCHDOG_LIMIT = 200;
    localparam int POS_MAX        = (1 << POS_W) - 1;

    localparam logic ST_OK   = 1'b0;
    localparam logic ST_FAIL = 1'b1;

    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_CLEAR + 1;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = {OP_W{1'b1}};

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word res;
    } t_dir_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_word  in_word   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;

    bit        idle_en     = 1'b1;
    int        stall_left  = 0;
    int        quiet_cycles = 0;
    int        errors      = 0;
    int        rand_sent   = 0;
    t_out_word want;

    t_data     list_shadow[$];
    t_out_word pending_results[$];

    t_dir_row dir_rows [26] = '{
        '{'{OP_RD_FRONT,  7'd0,   32'h0000_0000}, 1'b1, '{ST_FAIL, 32'h0, 7'd0, 1'b0}},
        '{'{OP_REM_BACK,  7'd0,   32'h0000_0000}, 1'b1, '{ST_FAIL, 32'h0, 7'd0, 1'b0}},
        '{'{OP_RD_AT,     7'd0,   32'h0000_0000}, 1'b1, '{ST_FAIL, 32'h0, 7'd0, 1'b0}},
        '{'{OP_INS_AT,    7'd1,   32'h1234_5678}, 1'b1, '{ST_FAIL, 32'h0, 7'd0, 1'b0}},
        '{'{OP_INS_AT,    7'd0,   32'h0000_0000}, 1'b1, '{ST_OK,   32'h0, 7'd1, 1'b1}},
        '{'{OP_INS_FRONT, 7'd0,   32'hFFFF_FFFF}, 1'b1, '{ST_OK,   32'h0, 7'd2, 1'b1}},
        '{'{OP_INS_BACK,  7'd127, 32'h8000_0001}, 1'b1, '{ST_OK,   32'h0, 7'd3, 1'b1}},
        '{'{OP_RD_FRONT,  7'd0,   32'h0000_0000}, 1'b1,
          '{ST_OK, 32'hFFFF_FFFF, 7'd3, 1'b1}},
        '{'{OP_RD_BACK,   7'd0,   32'h0000_0000}, 1'b1,
          '{ST_OK, 32'h8000_0001, 7'd3, 1'b1}},
        '{'{OP_RD_AT,     7'd1,   32'h0000_0000}, 1'b1, '{ST_OK,   32'h0, 7'd3, 1'b1}},
        '{'{OP_RD_AT,     7'd3,   32'h0000_0000}, 1'b1, '{ST_FAIL, 32'h0, 7'd3, 1'b1}},
        '{'{OP_RD_AT,     7'd127, 32'hFFFF_FFFF}, 1'b1, '{ST_FAIL, 32'h0, 7'd3, 1'b1}},
        '{'{OP_INS_AT,    7'd3,   32'h5555_AAAA}, 1'b0, '0},
        '{'{OP_INS_AT,    7'd2,   32'hAAAA_5555}, 1'b0, '0},
        '{'{OP_REM_AT,    7'd4,   32'h0000_0000}, 1'b0, '0},
        '{'{OP_REM_AT,    7'd4,   32'h0000_0000}, 1'b0, '0},
        '{'{OP_REM_AT,    7'd1,   32'h0000_0000}, 1'b0, '0},
        '{'{OP_REM_FRONT, 7'd0,   32'h0000_0000}, 1'b0, '0},
        '{'{OP_REM_BACK,  7'd0,   32'h0000_0000}, 1'b0, '0},
        '{'{OP_UNUSED_LO, 7'd0,   32'hFFFF_FFFF}, 1'b0, '0},
        '{'{OP_UNUSED_HI, 7'd127, 32'hFFFF_FFFF}, 1'b0, '0},
        '{'{OP_CLEAR,     7'd0,   32'h0000_0000}, 1'b1, '{ST_OK,   32'h0, 7'd0, 1'b0}},
        '{'{OP_CLEAR,     7'd5,   32'hFFFF_FFFF}, 1'b1, '{ST_OK,   32'h0, 7'd0, 1'b0}},
        '{'{OP_REM_AT,    7'd0,   32'h0000_0000}, 1'b1, '{ST_FAIL, 32'h0, 7'd0, 1'b0}},
        '{'{OP_INS_AT,    7'd64,  32'h0000_0007}, 1'b1, '{ST_FAIL, 32'h0, 7'd0, 1'b0}},
        '{'{OP_INS_BACK,  7'd0,   32'h0000_0007}, 1'b1, '{ST_OK,   32'h0, 7'd1, 1'b1}}
    };

    positional_list_engine_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // updates the list copy and returns the word the block must answer with
    function automatic t_out_word apply_list_op(input t_in_word w);
        t_out_word r;
        int        n;
        int        p;
        n = list_shadow.size();
        p = w.position;
        r = '0;
        r.status = ST_FAIL;
        case (w.op)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (w.op == OP_INS_FRONT) p = 0;
                if (w.op == OP_INS_BACK) p = n;
                if (n < CAPACITY && p <= n) begin
                    list_shadow.insert(p, w.value[DATA_WIDTH-1:0]);
                    r.status = ST_OK;
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT,
            OP_RD_FRONT, OP_RD_BACK, OP_RD_AT: begin
                if (w.op == OP_REM_FRONT || w.op == OP_RD_FRONT) p = 0;
                if (w.op == OP_REM_BACK || w.op == OP_RD_BACK) p = n - 1;
                if (p >= 0 && p < n) begin
                    r.read_data = VAL_W'(list_shadow[p]);
                    r.status    = ST_OK;
                    if (w.op == OP_REM_FRONT || w.op == OP_REM_BACK || w.op == OP_REM_AT)
                        list_shadow.delete(p);
                end
            end
            OP_CLEAR: begin
                list_shadow.delete();
                r.status = ST_OK;
            end
            default: r.status = ST_FAIL;
        endcase
        r.entry_count = POS_W'(list_shadow.size());
        r.nonempty    = (list_shadow.size() != 0);
        return r;
    endfunction

    // mostly in range, sometimes past it
    function automatic logic [POS_W-1:0] pick_pos(input int hi);
        if (hi < 0 || $urandom_range(0, 9) == 0)
            return POS_W'($urandom_range((hi < 0) ? 0 : hi + 1, POS_MAX));
        return POS_W'($urandom_range(0, hi));
    endfunction

    function automatic t_in_word make_op_word(input logic [OP_W-1:0] op);
        t_in_word w;
        w.op    = op;
        w.value = $urandom;
        if (op == OP_INS_FRONT || op == OP_INS_BACK || op == OP_INS_AT)
            w.position = pick_pos(list_shadow.size());
        else
            w.position = pick_pos(list_shadow.size() - 1);
        return w;
    endfunction

    task automatic issue_op(input t_in_word w, input bit typed, input t_out_word typed_res);
        t_out_word res;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (in_stall);
        res = apply_list_op(w);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic issue_rand(input t_in_word w);
        if (rand_sent >= RAND_ITEMS - QUIET_TAIL) idle_en = 1'b0;
        issue_op(w, 1'b0, '0);
        rand_sent++;
    endtask

    initial begin : stimulus
        t_in_word w;
        int       kind;
        int       n;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_rows[i])
            issue_op(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

        while (rand_sent < RAND_ITEMS) begin
            idle_en = ($urandom_range(0, 3) != 0) && (rand_sent < RAND_ITEMS - QUIET_TAIL);
            kind = $urandom_range(0, 9);
            if (kind < 2) begin
                // fill up to full, then push against it
                while (list_shadow.size() < CAPACITY)
                    issue_rand(make_op_word(t_op'($urandom_range(OP_INS_FRONT, OP_INS_AT))));
                repeat ($urandom_range(1, 3))
                    issue_rand(make_op_word(t_op'($urandom_range(OP_INS_FRONT, OP_INS_AT))));
            end else if (kind < 4) begin
                // drain to empty, then poke the empty list
                while (list_shadow.size() > 0) begin
                    if ($urandom_range(0, 3) != 0)
                        issue_rand(make_op_word(t_op'($urandom_range(OP_REM_FRONT, OP_REM_AT))));
                    else
                        issue_rand(make_op_word(t_op'($urandom_range(OP_RD_FRONT, OP_RD_AT))));
                end
                repeat ($urandom_range(1, 2))
                    issue_rand(make_op_word(t_op'($urandom_range(OP_REM_FRONT, OP_RD_AT))));
            end else if (kind < 9) begin
                n = $urandom_range(20, 40);
                repeat (n) begin
                    if ($urandom_range(0, 29) == 0)
                        issue_rand(make_op_word(OP_CLEAR));
                    else
                        issue_rand(make_op_word(t_op'($urandom_range(OP_INS_FRONT, OP_RD_AT))));
                end
            end else begin
                n = $urandom_range(5, 10);
                repeat (n) begin
                    w.op       = OP_W'($urandom_range(0, OP_UNUSED_HI));
                    w.position = POS_W'($urandom_range(0, POS_MAX));
                    w.value    = $urandom;
                    issue_rand(w);
                end
            end
        end

        idle_en = 1'b0;
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (rst_n && idle_en && $urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 4);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected word, expected none actual %p", $time, out_word);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (out_word.status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, out_word.status);
                    errors++;
                end
                if (out_word.read_data !== want.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want.read_data, out_word.read_data);
                    errors++;
                end
                if (out_word.entry_count !== want.entry_count) begin
                    $display("%0t: entry_count expected %0d actual %0d",
                             $time, want.entry_count, out_word.entry_count);
                    errors++;
                end
                if (out_word.nonempty !== want.nonempty) begin
                    $display("%0t: nonempty expected %0d actual %0d",
                             $time, want.nonempty, out_word.nonempty);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
